### sv/lcd_dot_timing_stat_irq_unit_assert.svh
// Assertion macros shared by the LCD dot timing checks
`ifndef LCD_DOT_TIMING_STAT_IRQ_UNIT_ASSERT_SVH
`define LCD_DOT_TIMING_STAT_IRQ_UNIT_ASSERT_SVH

// Same-cycle check: when the antecedent holds, the consequent holds too
`define LDTSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle check: when the antecedent holds, the consequent holds in the following cycle
`define LDTSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ldtsi_pkg.sv
// Types and constants for the LCD dot timing and STAT interrupt unit
`default_nettype none

package ldtsi_pkg;

  // Frame geometry
  localparam logic [8:0] DOTS_PER_LINE   = 9'd456;
  localparam logic [7:0] LINES_PER_FRAME = 8'd154;
  localparam logic [7:0] VISIBLE_LINES   = 8'd144;
  localparam logic [8:0] OAM_END_DOT     = 9'd80;
  localparam logic [8:0] DRAW_END_DOT    = 9'd252;

  // Bits of the STAT source enable register
  localparam int STAT_EN_HBLANK = 0;
  localparam int STAT_EN_VBLANK = 1;
  localparam int STAT_EN_OAM    = 2;
  localparam int STAT_EN_LYC    = 3;

  // Video mode codes
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_WINDOW_ON   = 2'd0,
    REG_WINDOW_Y    = 2'd1,
    REG_LYC_COMPARE = 2'd2,
    REG_STAT_ENABLES = 2'd3
  } reg_idx_t;

  // One result per dot tick
  typedef struct packed {
    mode_t      video_mode;
    logic [7:0] line_number;
    logic [8:0] dot_number;
    logic       coincidence;
    logic       stat_irq;
    logic       vblank_irq;
    logic       hdma_request;
    logic [7:0] window_line;
    logic       window_line_active;
    logic [7:0] draw_x;
    logic       stat_flag_clear;
  } result_t;

endpackage

`default_nettype wire

### sv/lcd_dot_timing_stat_irq_unit.sv
// LCD dot timing, mode sequencing and STAT interrupt unit (top level)
// Each accepted request is one dot tick with the LCD enable bit; the unit
// answers every tick with one result (mode, LY, dot, LYC coincidence,
// interrupt pulses, window line counter, draw column). One tick is accepted
// every clock while item_stall is low: the dot/line counters and mode state
// update on each accepted tick and the result is registered. A two-entry
// output buffer (result register plus skid register) lets a new tick be
// accepted while a result waits; item_stall rises only once both are full.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8
// and 12 and should be written only while no ticks are in flight.
`default_nettype none

module lcd_dot_timing_stat_irq_unit import ldtsi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Dot tick requests
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        lcd_on,
  // Results
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic      [1:0]  video_mode,
  output logic      [7:0]  line_number,
  output logic      [8:0]  dot_number,
  output logic             coincidence,
  output logic             stat_irq,
  output logic             vblank_irq,
  output logic             hdma_request,
  output logic      [7:0]  window_line,
  output logic             window_line_active,
  output logic      [7:0]  draw_x,
  output logic             stat_flag_clear
);

  // Configuration registers
  logic       window_on;
  logic [7:0] window_y;
  logic [7:0] lyc_compare;
  logic [3:0] stat_enables;
  reg_idx_t   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_on     <= 1'b0;
      window_y      <= 8'd0;
      lyc_compare   <= 8'd0;
      stat_enables  <= 4'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_WINDOW_ON:     window_on     <= pwdata[0];
        REG_WINDOW_Y:      window_y      <= pwdata[7:0];
        REG_LYC_COMPARE:   lyc_compare   <= pwdata[7:0];
        REG_STAT_ENABLES:  stat_enables  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_WINDOW_ON:     prdata = {31'd0, window_on};
      REG_WINDOW_Y:      prdata = {24'd0, window_y};
      REG_LYC_COMPARE:   prdata = {24'd0, lyc_compare};
      REG_STAT_ENABLES:  prdata = {28'd0, stat_enables};
      default:           prdata = 32'd0;
    endcase
  end

  // Timing state
  logic [8:0] dot_count,       dot_count_next;
  logic [7:0] line_count,      line_count_next;
  mode_t      mode_reg,        mode_reg_next;
  logic       stat_line,       stat_line_next;
  logic       window_vertical, window_vertical_next;
  logic [7:0] window_counter,  window_counter_next;
  logic       hdma_done,       hdma_done_next;
  logic [7:0] pixel_x,         pixel_x_next;

  // Output buffer
  result_t out_q, skid_q, res;
  logic    out_valid, skid_valid;
  logic    item_accept, out_take;

  assign item_stall  = skid_valid;
  assign item_accept = item_valid && !item_stall;
  assign out_take    = out_valid && !result_stall;

  // Per-tick next state and result
  always_comb begin
    logic       visible;
    logic       sig;
    logic [7:0] px_base;

    dot_count_next       = dot_count;
    line_count_next      = line_count;
    mode_reg_next        = mode_reg;
    window_vertical_next = window_vertical;
    window_counter_next  = window_counter;
    hdma_done_next       = hdma_done;
    pixel_x_next         = pixel_x;
    stat_line_next       = stat_line;
    visible              = line_count < VISIBLE_LINES;
    sig                  = 1'b0;
    px_base              = (mode_reg != MODE_DRAW) ? 8'd0 : pixel_x;

    res                    = '0;
    res.coincidence        = (line_count == lyc_compare);
    res.line_number        = line_count;
    res.dot_number         = dot_count;

    if (!lcd_on) begin
      // Display held in reset
      dot_count_next       = 9'd0;
      line_count_next      = 8'd0;
      mode_reg_next        = MODE_HBLANK;
      window_vertical_next = 1'b0;
      window_counter_next  = 8'd0;
      hdma_done_next       = 1'b0;
      pixel_x_next         = 8'd0;
      stat_line_next       = 1'b0;
      res                  = '0;
      res.video_mode       = MODE_HBLANK;
      res.coincidence      = (lyc_compare == 8'd0);
      res.stat_flag_clear  = 1'b1;
    end else begin
      // Window line counter, updated at the start of each line
      if (dot_count == 9'd0) begin
        if (!window_on || !visible) begin
          window_vertical_next = 1'b0;
        end else if (line_count == window_y) begin
          window_vertical_next = 1'b1;
          window_counter_next  = 8'd0;
        end else if (window_vertical) begin
          window_counter_next  = window_counter + 8'd1;
        end
      end

      // Mode sequencing
      if (visible) begin
        if (dot_count < OAM_END_DOT) begin
          mode_reg_next = MODE_OAM;
        end else if (dot_count < DRAW_END_DOT) begin
          mode_reg_next = MODE_DRAW;
          res.draw_x    = px_base;
          pixel_x_next  = px_base + 8'd1;
        end else begin
          mode_reg_next = MODE_HBLANK;
          if (mode_reg != MODE_HBLANK) pixel_x_next = 8'd0;
          if (!hdma_done) begin
            res.hdma_request = 1'b1;
            hdma_done_next   = 1'b1;
          end
        end
      end else if (mode_reg != MODE_VBLANK) begin
        mode_reg_next       = MODE_VBLANK;
        window_counter_next = 8'd0;
        res.vblank_irq      = 1'b1;
      end

      // Combined STAT level and its rising edge
      sig = (stat_enables[STAT_EN_LYC]    && res.coincidence) ||
            (stat_enables[STAT_EN_OAM]    && mode_reg_next == MODE_OAM) ||
            (stat_enables[STAT_EN_VBLANK] && mode_reg_next == MODE_VBLANK) ||
            (stat_enables[STAT_EN_HBLANK] && mode_reg_next == MODE_HBLANK);
      res.stat_irq   = sig && !stat_line;
      stat_line_next = sig;

      res.video_mode         = mode_reg_next;
      res.window_line        = window_counter_next;
      res.window_line_active = window_vertical_next;

      // Dot and line advance
      if (dot_count >= DOTS_PER_LINE - 9'd1) begin
        dot_count_next  = 9'd0;
        hdma_done_next  = 1'b0;
        line_count_next = (line_count >= LINES_PER_FRAME - 8'd1) ? 8'd0
                                                                 : line_count + 8'd1;
      end else begin
        dot_count_next  = dot_count + 9'd1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count       <= 9'd0;
      line_count      <= 8'd0;
      mode_reg        <= MODE_HBLANK;
      stat_line       <= 1'b0;
      window_vertical <= 1'b0;
      window_counter  <= 8'd0;
      hdma_done       <= 1'b0;
      pixel_x         <= 8'd0;
    end else if (item_accept) begin
      dot_count       <= dot_count_next;
      line_count      <= line_count_next;
      mode_reg        <= mode_reg_next;
      stat_line       <= stat_line_next;
      window_vertical <= window_vertical_next;
      window_counter  <= window_counter_next;
      hdma_done       <= hdma_done_next;
      pixel_x         <= pixel_x_next;
    end
  end

  // Output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= item_accept;
      end
    end else if (item_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) out_q <= skid_q;
      else if (item_accept) out_q <= res;
    end else if (item_accept) begin
      skid_q <= res;
    end
  end

  assign result_valid       = out_valid;
  assign video_mode         = out_q.video_mode;
  assign line_number        = out_q.line_number;
  assign dot_number         = out_q.dot_number;
  assign coincidence        = out_q.coincidence;
  assign stat_irq           = out_q.stat_irq;
  assign vblank_irq         = out_q.vblank_irq;
  assign hdma_request       = out_q.hdma_request;
  assign window_line        = out_q.window_line;
  assign window_line_active = out_q.window_line_active;
  assign draw_x             = out_q.draw_x;
  assign stat_flag_clear    = out_q.stat_flag_clear;

endmodule

`default_nettype wire

### sv/ldtsi_checker.sv
// Port-level checks for the LCD dot timing unit, bound to the top level
`default_nettype none
`include "lcd_dot_timing_stat_irq_unit_assert.svh"

module ldtsi_checker import ldtsi_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [1:0] video_mode,
  input wire logic [7:0] line_number,
  input wire logic [8:0] dot_number,
  input wire logic       stat_irq,
  input wire logic       vblank_irq,
  input wire logic       hdma_request,
  input wire logic [7:0] draw_x,
  input wire logic       stat_flag_clear
);

  // A vblank pulse only comes with a vblank result
  `LDTSI_ASSERT_NOW(a_vblank_mode, result_valid && vblank_irq, video_mode == MODE_VBLANK && line_number >= VISIBLE_LINES, "vblank pulse outside vblank")

  // The DMA request fires in hblank of a visible line
  `LDTSI_ASSERT_NOW(a_hdma_mode, result_valid && hdma_request, video_mode == MODE_HBLANK && line_number < VISIBLE_LINES && dot_number >= DRAW_END_DOT, "hblank DMA request outside visible hblank")

  // LCD off shows line 0, dot 0 in hblank, with no STAT pulse
  `LDTSI_ASSERT_NOW(a_lcd_off, result_valid && stat_flag_clear, video_mode == MODE_HBLANK && line_number == 8'd0 && dot_number == 9'd0 && !stat_irq, "LCD off result not held in reset")

  // A stalled result stays put
  `LDTSI_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(dot_number) && $stable(line_number) && $stable(draw_x), "stalled result changed")

endmodule

bind lcd_dot_timing_stat_irq_unit ldtsi_checker u_checker (.*);

`default_nettype wire
